@@ hw/rtl/mfbr_pkg.sv @@
// shared types and constants of the monochrome framebuffer rotator
package mfbr_pkg;

  // panel geometry
  localparam int COLUMNS = 128;
  localparam int PAGES   = 16;
  localparam int PANEL_H = PAGES * 8;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // field widths
  localparam int PAGE_W = 4;
  localparam int COL_W  = 7;
  localparam int DATA_W = 8;
  localparam int BIT_W  = 3;

  // signed coordinate width, covers every source pixel offset
  localparam int COORD_W = 10;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } mfbr_rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION,
    CFG_FLIP
  } mfbr_cfg_idx_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic              is_read;
    logic              in_range;
    mfbr_rot_t         rot;
    logic              flip;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
    logic [DATA_W-1:0] data;
  } mfbr_cmd_t;

  // read tap that rides alongside the registered ram read
  typedef struct packed {
    logic             live;
    logic             ok;
    logic [BIT_W-1:0] bidx;
    logic [BIT_W-1:0] ybit;
  } mfbr_tap_t;

endpackage

@@ hw/rtl/mfbr_in_if.sv @@
// input channel: write or read request with valid/ready
interface mfbr_in_if;
  import mfbr_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [PAGE_W-1:0] page;
  logic [COL_W-1:0]  column;
  logic [DATA_W-1:0] data;

  modport source (output valid, kind, page, column, data, input ready);
  modport sink   (input valid, kind, page, column, data, output ready);
endinterface

@@ hw/rtl/mfbr_out_if.sv @@
// result channel: transformed pixel byte with valid/ready
interface mfbr_out_if;
  import mfbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] pixel_byte;
  logic [COL_W-1:0]  out_column;

  modport source (output valid, pixel_byte, out_column, input ready);
  modport sink   (input valid, pixel_byte, out_column, output ready);
endinterface

@@ hw/rtl/mono_framebuffer_rotator_unit.sv @@
// Page-organized monochrome frame store with rotated and flipped read-out.
// in_ch carries requests: kind 0 stores data at (page, column), kind 1 asks
// for the panel byte at (page, column) and yields one transfer on out_ch
// with pixel_byte and out_column. Writes yield no transfer.
// cfg_we/cfg_index/cfg_wdata set rotation (index 0) and flip (index 1);
// write them only while no request is in flight.
// Requests enter a two-entry queue; the back end takes one per cycle when
// idle. A write is done in the back end as it is popped. A read is popped,
// then eight single-byte reads of the store follow (one per output bit, set
// by the single ram port), and a drain step collects the last bit before
// the byte goes to the output register. The back end starts the next read
// only when this one is done, while the queue can still take requests.
// After reset the store is cleared by a pass over all PAGES*COLUMNS
// addresses (2048 as built) during which in_ch.ready stays low; rotation
// and flip reset to 0. When out_ch stalls, the result is held in the output
// register while the next read is gathered; the back end then waits, the
// queue fills and in_ch.ready drops.
module mono_framebuffer_rotator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  mfbr_in_if.sink                         in_ch,
  mfbr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mfbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfbr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mfbr_pkg::*;

  logic      push, pop, q_valid, q_full, clearing;
  mfbr_cmd_t push_cmd, head_cmd;

  // accept and classify
  mfbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decoupling queue
  mfbr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head_cmd (head_cmd)
  );

  // execute against the store
  mfbr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head_cmd (head_cmd),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

@@ hw/rtl/mfbr_ram.sv @@
// generic single-port ram with registered read
module mfbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a write, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/mfbr_front.sv @@
// front end: configuration registers, range check and item classification
module mfbr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  mfbr_in_if.sink                     in_ch,
  input  logic                        cfg_we,
  input  logic [mfbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        push,
  output mfbr_pkg::mfbr_cmd_t         push_cmd
);
  import mfbr_pkg::*;

  mfbr_rot_t rotation_r;
  logic      flip_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= ROT_0;
      flip_r     <= 1'b0;
    end else if (cfg_we) begin
      case (mfbr_cfg_idx_t'(cfg_index))
        CFG_ROTATION: rotation_r <= mfbr_rot_t'(cfg_wdata[1:0]);
        CFG_FLIP:     flip_r     <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // accept while the queue has room and the store is not being cleared
  assign in_ch.ready = !q_full && !clearing;
  assign push        = in_ch.valid && in_ch.ready;

  // classify the item and capture the mode it runs under
  always_comb begin
    push_cmd.is_read  = in_ch.kind;
    push_cmd.in_range = (32'(in_ch.page) < PAGES) && (32'(in_ch.column) < COLUMNS);
    push_cmd.rot      = rotation_r;
    push_cmd.flip     = flip_r;
    push_cmd.page     = in_ch.page;
    push_cmd.column   = in_ch.column;
    push_cmd.data     = in_ch.data;
  end

endmodule

@@ hw/rtl/mfbr_queue.sv @@
// short command queue between front and back
module mfbr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mfbr_pkg::mfbr_cmd_t push_cmd,
  input  logic                pop,
  output logic                q_valid,
  output logic                q_full,
  output mfbr_pkg::mfbr_cmd_t head_cmd
);
  import mfbr_pkg::*;

  mfbr_cmd_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign q_valid  = (count_r != '0);
  assign q_full   = (count_r == QCNT_W'(QDEPTH));
  assign head_cmd = entry_r[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/mfbr_back.sv @@
// back end: clearing pass, store writes and the eight-read gather for every read
module mfbr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mfbr_pkg::mfbr_cmd_t head_cmd,
  output logic                pop,
  output logic                clearing,
  mfbr_out_if.source          out_ch
);
  import mfbr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(DATA_W - 1);
  localparam logic signed [COORD_W-1:0] H_S = COORD_W'(PANEL_H);
  localparam logic signed [COORD_W-1:0] C_S = COORD_W'(COLUMNS);
  localparam logic signed [COORD_W-1:0] ONE_S = COORD_W'(1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  mfbr_cmd_t         cmd_r, cmd_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  mfbr_tap_t         tap_r, tap_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_byte_r, out_byte_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [DATA_W-1:0]         ram_wdata;
  logic [DATA_W-1:0]         ram_rdata;
  logic signed [COORD_W-1:0] r_s, d_s, x_s, y_s;
  logic [COORD_W-1:0]        xu, yu;
  logic                      pix_ok;
  logic                      out_free;

  mfbr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // source pixel of the current output bit
  always_comb begin
    r_s = signed'(COORD_W'({cmd_r.page, bit_r}));
    d_s = signed'(COORD_W'(cmd_r.column));
    case (cmd_r.rot)
      ROT_0: begin
        x_s = d_s;
        y_s = cmd_r.flip ? (H_S - ONE_S - r_s) : r_s;
      end
      ROT_90: begin
        x_s = cmd_r.flip ? (H_S - ONE_S - r_s) : r_s;
        y_s = H_S - ONE_S - d_s;
      end
      ROT_180: begin
        x_s = C_S - ONE_S - d_s;
        y_s = cmd_r.flip ? r_s : (H_S - ONE_S - r_s);
      end
      ROT_270: begin
        x_s = cmd_r.flip ? r_s : (H_S - ONE_S - r_s);
        y_s = d_s;
      end
      default: begin
        x_s = d_s;
        y_s = r_s;
      end
    endcase
    xu     = unsigned'(x_s);
    yu     = unsigned'(y_s);
    pix_ok = cmd_r.in_range && (x_s >= 0) && (x_s < C_S) && (y_s >= 0) && (y_s < H_S);
  end

  assign clearing          = (state_r == ST_CLEAR);
  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = out_byte_r;
  assign out_ch.out_column = out_col_r;

  // sequencer next state, ram port and output register
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    bit_nxt       = bit_r;
    acc_nxt       = acc_r;
    tap_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_col_nxt   = out_col_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = ADDR_W'(yu[COORD_W-1:BIT_W] * COLUMNS + xu);
    ram_wdata     = head_cmd.data;

    // collect the bit whose read was issued last cycle
    if (tap_r.live) begin
      acc_nxt[tap_r.bidx] = tap_r.ok & ram_rdata[tap_r.ybit];
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (head_cmd.is_read) begin
            cmd_nxt   = head_cmd;
            bit_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = ST_RUN;
          end else begin
            ram_we   = head_cmd.in_range;
            ram_addr = ADDR_W'(head_cmd.page * COLUMNS + head_cmd.column);
          end
        end
      end
      ST_RUN: begin
        tap_nxt.live = 1'b1;
        tap_nxt.ok   = pix_ok;
        tap_nxt.bidx = bit_r;
        tap_nxt.ybit = yu[BIT_W-1:0];
        bit_nxt      = bit_r + 1'b1;
        if (bit_r == LAST_BIT) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_nxt;
          out_col_nxt   = cmd_r.column;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_r;
          out_col_nxt   = cmd_r.column;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    bit_r      <= bit_nxt;
    acc_r      <= acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_col_r  <= out_col_nxt;
  end

endmodule

@@ hw/rtl/mfbr_checker.sv @@
// port-level checks for the framebuffer rotator, bound to the top level
module mfbr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mfbr_pkg::DATA_W-1:0] out_pixel_byte,
  input logic [mfbr_pkg::COL_W-1:0]  out_column
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_byte) && $stable(out_column))
    else $error("stalled result changed");

  // reset starts the clearing pass, so no request is taken
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken right after reset");

  // reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // right after reset is released, no result is shown and no request is taken
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_ready)
    else $error("activity during clearing pass");

endmodule

bind mono_framebuffer_rotator_unit mfbr_checker u_mfbr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pixel_byte (out_ch.pixel_byte),
  .out_column     (out_ch.out_column)
);

@@ verif/tb_top.sv @@
// self-checking bench for the framebuffer rotator: directed table, then random phases per rotation
module tb_top;
  import mfbr_pkg::*;

  // request kinds on the input channel
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_PHASES    = 8;

  typedef struct {
    logic              kind;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
    logic [DATA_W-1:0] data;
    bit                typed;
    logic [DATA_W-1:0] want;
  } stim_row_t;

  typedef struct {
    logic [DATA_W-1:0] pixel_byte;
    logic [COL_W-1:0]  column;
  } byte_expect_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mfbr_in_if  req_ch ();
  mfbr_out_if res_ch ();

  mono_framebuffer_rotator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the frame store and the rotation registers
  logic [DATA_W-1:0] frame_copy [PAGES][COLUMNS];
  mfbr_rot_t         cur_rot;
  logic              cur_flip;
  byte_expect_t      pending_bytes [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count   = 0;
  int reads_checked = 0;
  int stores_sent;
  int cycle_count   = 0;

  // directed table: corners, data extremes, overwrite; expected bytes after reset are literal
  stim_row_t directed_rows [16] = '{
    '{KIND_READ,  4'd0,  7'd0,   8'h00, 1'b1, 8'h00},
    '{KIND_READ,  4'd15, 7'd127, 8'hff, 1'b1, 8'h00},
    '{KIND_WRITE, 4'd0,  7'd0,   8'hff, 1'b0, 8'h00},
    '{KIND_WRITE, 4'd15, 7'd127, 8'ha5, 1'b0, 8'h00},
    '{KIND_WRITE, 4'd0,  7'd127, 8'h01, 1'b0, 8'h00},
    '{KIND_WRITE, 4'd15, 7'd0,   8'h80, 1'b0, 8'h00},
    '{KIND_READ,  4'd0,  7'd0,   8'h00, 1'b1, 8'hff},
    '{KIND_READ,  4'd15, 7'd127, 8'h00, 1'b1, 8'ha5},
    '{KIND_READ,  4'd0,  7'd127, 8'h00, 1'b1, 8'h01},
    '{KIND_READ,  4'd15, 7'd0,   8'h00, 1'b1, 8'h80},
    '{KIND_WRITE, 4'd7,  7'd64,  8'h00, 1'b0, 8'h00},
    '{KIND_READ,  4'd7,  7'd64,  8'h00, 1'b1, 8'h00},
    '{KIND_WRITE, 4'd8,  7'd63,  8'h5a, 1'b0, 8'h00},
    '{KIND_READ,  4'd8,  7'd63,  8'h00, 1'b1, 8'h5a},
    '{KIND_WRITE, 4'd0,  7'd0,   8'h00, 1'b0, 8'h00},
    '{KIND_READ,  4'd0,  7'd0,   8'h00, 1'b1, 8'h00}
  };

  // rotation and flip used by each random phase
  mfbr_rot_t phase_rot  [NUM_PHASES] = '{ROT_0, ROT_90, ROT_90, ROT_180,
                                         ROT_180, ROT_270, ROT_270, ROT_0};
  bit        phase_flip [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  // byte the panel gets at (pg, col) under the current rotation and flip
  function automatic logic [DATA_W-1:0] panel_byte(input logic [PAGE_W-1:0] pg,
                                                   input logic [COL_W-1:0] col);
    logic [DATA_W-1:0] acc;
    int b;
    int r;
    int x;
    int y;
    acc = '0;
    if (int'(pg) >= PAGES || int'(col) >= COLUMNS) return '0;
    if (cur_rot == ROT_0) begin
      if (!cur_flip) return frame_copy[pg][col];
      for (b = 0; b < 8; b++) acc[7-b] = frame_copy[PAGES-1-int'(pg)][col][b];
      return acc;
    end
    for (b = 0; b < 8; b++) begin
      r = int'(pg) * 8 + b;
      case (cur_rot)
        ROT_90: begin
          x = cur_flip ? PANEL_H - 1 - r : r;
          y = PANEL_H - 1 - int'(col);
        end
        ROT_180: begin
          x = COLUMNS - 1 - int'(col);
          y = cur_flip ? r : PANEL_H - 1 - r;
        end
        default: begin
          x = cur_flip ? r : PANEL_H - 1 - r;
          y = int'(col);
        end
      endcase
      // source pixels off the store read as zero
      if (x >= 0 && x < COLUMNS && y >= 0 && y < PANEL_H)
        acc[b] = frame_copy[y / 8][x][y % 8];
    end
    return acc;
  endfunction

  // one request transfer, with random gaps ahead of it
  task automatic send_item(input logic kind, input logic [PAGE_W-1:0] pg,
                           input logic [COL_W-1:0] col, input logic [DATA_W-1:0] dat,
                           input bit typed, input logic [DATA_W-1:0] want);
    byte_expect_t e;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.kind   <= kind;
    req_ch.page   <= pg;
    req_ch.column <= col;
    req_ch.data   <= dat;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // transfer taken: update the shadow store or queue the expected byte
    if (kind == KIND_WRITE) begin
      frame_copy[pg][col] = dat;
      stores_sent++;
    end else begin
      e.pixel_byte = typed ? want : panel_byte(pg, col);
      e.column     = col;
      pending_bytes.push_back(e);
    end
  endtask

  // hold off requests until every read result is back
  task automatic drain(input int settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // write both registers; upper flip bit is random and must be ignored
  task automatic set_config(input mfbr_rot_t rot, input logic flp);
    logic [CFG_DATA_W-1:0] flip_word;
    flip_word    = CFG_DATA_W'($urandom_range(0, 3));
    flip_word[0] = flp;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROTATION;
    cfg_wdata <= rot;
    @(posedge clk);
    cur_rot = rot;
    cfg_index <= CFG_FLIP;
    cfg_wdata <= flip_word;
    @(posedge clk);
    cur_flip = flip_word[0];
    cfg_we <= 1'b0;
  endtask

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    byte_expect_t head;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: pixel_byte %0h out_column %0d",
               res_ch.pixel_byte, res_ch.out_column);
        error_count++;
      end else begin
        head = pending_bytes.pop_front();
        reads_checked++;
        if (res_ch.pixel_byte !== head.pixel_byte) begin
          $error("pixel_byte: expected %0h, got %0h", head.pixel_byte, res_ch.pixel_byte);
          error_count++;
        end
        if (res_ch.out_column !== head.column) begin
          $error("out_column: expected %0d, got %0d", head.column, res_ch.out_column);
          error_count++;
        end
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // main sequence
  initial begin
    int ph;
    int n;
    int c;
    int sel;
    logic [DATA_W-1:0] dat;
    send_idle_pct = 35;
    recv_idle_pct = 63;
    stores_sent   = 0;
    cur_rot       = ROT_0;
    cur_flip      = 1'b0;
    foreach (frame_copy[p, k]) frame_copy[p][k] = '0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ROTATION;
    cfg_wdata     <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.kind   <= KIND_WRITE;
    req_ch.page   <= '0;
    req_ch.column <= '0;
    req_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(ROT_0, 1'b0);

    // directed table
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].page, directed_rows[i].column,
                directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

    // random phases, one per rotation and flip setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      set_config(phase_rot[ph], phase_flip[ph]);
      if (ph < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 63;
      end else if (ph < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // corner reads under the new setting
      for (c = 0; c < 4; c++)
        send_item(KIND_READ, c[1] ? 4'd15 : 4'd0, c[0] ? 7'd127 : 7'd0,
                  DATA_W'($urandom), 1'b0, '0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 63) == 0) drain(0);
        sel = $urandom_range(0, 3);
        if (sel == 0) dat = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else if (sel == 1) dat = 8'h01 << $urandom_range(0, 7);
        else dat = DATA_W'($urandom);
        send_item(($urandom_range(0, 99) < 55) ? KIND_WRITE : KIND_READ,
                  PAGE_W'($urandom_range(0, PAGES - 1)),
                  COL_W'($urandom_range(0, COLUMNS - 1)), dat, 1'b0, '0);
      end
    end

    drain(SETTLE_CYCLES);
    $display("covered %0d stores and %0d checked reads", stores_sent, reads_checked);
    $display("over all four rotations with and without flip, under stalls on both sides");
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
